@@ design/fmpd_pkg.sv @@
package fmpd_pkg;

    // Sample and product widths
    localparam int SAMPLE_W    = 8;
    localparam int PROD_W      = 17;
    // Products are scaled up before rotation to keep the shifted bits
    localparam int SCALE_SHIFT = 20;
    // Enough headroom for the CORDIC gain on a scaled 17-bit vector
    localparam int DATA_W      = PROD_W + SCALE_SHIFT + 3;
    localparam int ANGLE_W     = 32;
    localparam int OUT_W       = 16;
    localparam int ATAN_DEPTH  = 24;

    // atan(2^-k) as a fraction of a turn, 2^32 per turn
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // Vector handed from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0]  re;
        logic signed [DATA_W-1:0]  im;
        logic        [ANGLE_W-1:0] ang;
        logic                      zero;
    } cordic_vec_t;

endpackage

@@ design/fmpd_cordic_cell.sv @@
module fmpd_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  fmpd_pkg::cordic_vec_t up_vec,
    output logic                dn_valid,
    input  logic                dn_ready,
    output fmpd_pkg::cordic_vec_t dn_vec
);

    logic                          valid_reg;
    fmpd_pkg::cordic_vec_t         vec_reg;
    fmpd_pkg::cordic_vec_t         vec_next;
    logic signed [fmpd_pkg::DATA_W-1:0] re_in;
    logic signed [fmpd_pkg::DATA_W-1:0] im_in;
    logic signed [fmpd_pkg::DATA_W-1:0] re_sh;
    logic signed [fmpd_pkg::DATA_W-1:0] im_sh;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_vec   = vec_reg;

    // One micro-rotation; arithmetic shifts round toward minus infinity
    always_comb
    begin
        re_in = up_vec.re;
        im_in = up_vec.im;
        re_sh = re_in >>> STAGE;
        im_sh = im_in >>> STAGE;
        vec_next.zero = up_vec.zero;
        if (!im_in[fmpd_pkg::DATA_W-1])
        begin
            vec_next.re  = re_in + im_sh;
            vec_next.im  = im_in - re_sh;
            vec_next.ang = up_vec.ang + fmpd_pkg::ATAN_TURNS[STAGE];
        end
        else
        begin
            vec_next.re  = re_in - im_sh;
            vec_next.im  = im_in + re_sh;
            vec_next.ang = up_vec.ang - fmpd_pkg::ATAN_TURNS[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            vec_reg <= vec_next;
        end
    end

endmodule

@@ design/fmpd_front.sv @@
module fmpd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [7:0]            i_byte,
    input  logic [7:0]            q_byte,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output fmpd_pkg::cordic_vec_t dn_vec
);

    // Stage 0: offset removal, previous sample
    logic                                 s0_valid_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] s0_cur_i_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] s0_cur_q_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] s0_prev_i_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] s0_prev_q_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] prev_i_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] prev_q_reg;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] cur_i_next;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] cur_q_next;
    logic                                 s0_ready;
    logic                                 accept;

    // Stage 1: conjugate product
    logic                               s1_valid_reg;
    logic signed [fmpd_pkg::PROD_W-1:0] s1_re_reg;
    logic signed [fmpd_pkg::PROD_W-1:0] s1_im_reg;
    logic signed [15:0]                 p_ii;
    logic signed [15:0]                 p_qq;
    logic signed [15:0]                 p_qi;
    logic signed [15:0]                 p_iq;
    logic signed [fmpd_pkg::PROD_W-1:0] re_next;
    logic signed [fmpd_pkg::PROD_W-1:0] im_next;
    logic                               s1_ready;

    // Stage 2: scale and fold into right half plane
    logic                                s2_valid_reg;
    fmpd_pkg::cordic_vec_t               s2_vec_reg;
    fmpd_pkg::cordic_vec_t               s2_vec_next;
    logic signed [fmpd_pkg::DATA_W-1:0]  re_scaled;
    logic signed [fmpd_pkg::DATA_W-1:0]  im_scaled;
    logic                                s2_ready;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign up_ready = s0_ready;
    assign accept   = up_valid && s0_ready;
    assign dn_valid = s2_valid_reg;
    assign dn_vec   = s2_vec_reg;

    // Offset binary to two's complement: flip the top bit
    assign cur_i_next = {~i_byte[7], i_byte[6:0]};
    assign cur_q_next = {~q_byte[7], q_byte[6:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            prev_i_reg   <= '0;
            prev_q_reg   <= '0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= up_valid;
            end
            if (accept)
            begin
                prev_i_reg <= cur_i_next;
                prev_q_reg <= cur_q_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_cur_i_reg  <= cur_i_next;
            s0_cur_q_reg  <= cur_q_next;
            s0_prev_i_reg <= prev_i_reg;
            s0_prev_q_reg <= prev_q_reg;
        end
    end

    // cur * conj(prev)
    always_comb
    begin
        p_ii    = 16'(s0_cur_i_reg) * 16'(s0_prev_i_reg);
        p_qq    = 16'(s0_cur_q_reg) * 16'(s0_prev_q_reg);
        p_qi    = 16'(s0_cur_q_reg) * 16'(s0_prev_i_reg);
        p_iq    = 16'(s0_cur_i_reg) * 16'(s0_prev_q_reg);
        re_next = fmpd_pkg::PROD_W'(p_ii) + fmpd_pkg::PROD_W'(p_qq);
        im_next = fmpd_pkg::PROD_W'(p_qi) - fmpd_pkg::PROD_W'(p_iq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_valid_reg)
        begin
            s1_re_reg <= re_next;
            s1_im_reg <= im_next;
        end
    end

    // Left half plane: rotate by half a turn first
    always_comb
    begin
        re_scaled = fmpd_pkg::DATA_W'(s1_re_reg) <<< fmpd_pkg::SCALE_SHIFT;
        im_scaled = fmpd_pkg::DATA_W'(s1_im_reg) <<< fmpd_pkg::SCALE_SHIFT;
        s2_vec_next.zero = (s1_re_reg == '0) && (s1_im_reg == '0);
        if (s1_re_reg[fmpd_pkg::PROD_W-1])
        begin
            s2_vec_next.re  = -re_scaled;
            s2_vec_next.im  = -im_scaled;
            s2_vec_next.ang = fmpd_pkg::HALF_TURN;
        end
        else
        begin
            s2_vec_next.re  = re_scaled;
            s2_vec_next.im  = im_scaled;
            s2_vec_next.ang = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_vec_reg <= s2_vec_next;
        end
    end

endmodule

@@ design/fm_phase_discriminator.sv @@
// Registers in order: offset/sample register, product, quadrant fold, one cell
// per CORDIC iteration, rounding register. Throughput: one I/Q pair per cycle
// while out_stall is low; every stage holds its own valid bit, so bubbles
// close up under output stall.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the previous
// sample to zero, so the first output after reset is 0.
module fm_phase_discriminator #(
    parameter int PHASE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         q_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] phase_step
);

    localparam int DROP = fmpd_pkg::ANGLE_W - PHASE_BITS;
    localparam logic [fmpd_pkg::ANGLE_W-1:0] ROUND_ADD =
        fmpd_pkg::ANGLE_W'(1) << (DROP - 1);
    localparam logic [fmpd_pkg::ANGLE_W-1:0] ROUND_MASK =
        ~((fmpd_pkg::ANGLE_W'(1) << DROP) - fmpd_pkg::ANGLE_W'(1));

    fmpd_pkg::cordic_vec_t chain_vec [CORDIC_STAGES+1];
    logic                  chain_vld [CORDIC_STAGES+1];
    logic                  chain_rdy [CORDIC_STAGES+1];
    logic                  front_ready;

    logic                          out_valid_reg;
    logic signed [15:0]            phase_reg;
    logic signed [15:0]            phase_next;
    logic [fmpd_pkg::ANGLE_W-1:0]  ang_rounded;
    logic                          out_ready;

    assign in_stall = !front_ready;

    fmpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .i_byte   (i_byte),
        .q_byte   (q_byte),
        .dn_valid (chain_vld[0]),
        .dn_ready (chain_rdy[0]),
        .dn_vec   (chain_vec[0])
    );

    // Row of micro-rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        fmpd_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_vld[g]),
            .up_ready (chain_rdy[g]),
            .up_vec   (chain_vec[g]),
            .dn_valid (chain_vld[g+1]),
            .dn_ready (chain_rdy[g+1]),
            .dn_vec   (chain_vec[g+1])
        );
    end

    // Round to PHASE_BITS and keep the top half; zero vector gives 0
    assign out_ready = !out_valid_reg || !out_stall;
    assign chain_rdy[CORDIC_STAGES] = out_ready;

    always_comb
    begin
        ang_rounded = (chain_vec[CORDIC_STAGES].ang + ROUND_ADD) & ROUND_MASK;
        if (chain_vec[CORDIC_STAGES].zero)
        begin
            phase_next = '0;
        end
        else
        begin
            phase_next = ang_rounded[fmpd_pkg::ANGLE_W-1 -: fmpd_pkg::OUT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= chain_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && chain_vld[CORDIC_STAGES])
        begin
            phase_reg <= phase_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign phase_step = phase_reg;

endmodule

@@ design/fmpd_checker.sv @@
module fmpd_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] phase_step
);

    localparam int DEPTH = CORDIC_STAGES + 4;
    localparam int CNT_W = $clog2(DEPTH + 1) + 1;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // Items taken in but not yet handed out
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phase_step))
        else $error("phase_step changed while stalled");

    // No result without a matching input
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result with no input in flight");

    // An empty pipeline always takes input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> !in_stall)
        else $error("input stalled while pipeline empty");

    // Never more items in flight than there are stages
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind fm_phase_discriminator fmpd_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_fmpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .phase_step (phase_step)
);
